@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the byte-transfer I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned MaxBytesDef = 256;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_ST_LOW      = 4'd1,
    PH_WB_LOAD     = 4'd2,
    PH_WB_SET      = 4'd3,
    PH_WB_RISE     = 4'd4,
    PH_WB_FALL     = 4'd5,
    PH_ACK_REL     = 4'd6,
    PH_ACK_SAMPLE  = 4'd7,
    PH_RB_RISE     = 4'd8,
    PH_RB_SAMPLE   = 4'd9,
    PH_RB_ACK      = 4'd10,
    PH_RB_ACK_RISE = 4'd11,
    PH_RB_ACK_FALL = 4'd12,
    PH_STOP_LOW    = 4'd13,
    PH_STOP_RISE   = 4'd14,
    PH_STOP_END    = 4'd15
  } i2cm_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] target_addr;
    logic [8:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
    logic       scl_in;
  } i2cm_item_t;

  typedef struct packed {
    logic       sda_out;
    logic       scl_out;
    logic       byte_taken;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       done_res;
    logic       success;
  } i2cm_res_t;

endpackage

@@ rtl/i2cm_in_stage.sv @@
// ----------------------------------------------------------------------------
// i2cm_in_stage
// Input register: holds one bus tick item until the engine steps on it.
// ----------------------------------------------------------------------------
module i2cm_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2cm_pkg::i2cm_item_t item_i,
  input  logic               take_i,
  output logic               valid_o,
  output i2cm_pkg::i2cm_item_t item_o
);
  import i2cm_pkg::*;

  logic       valid_q;
  i2cm_item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/i2cm_engine.sv @@
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus phase sequencer: one pin step per item, START, address, data, STOP.
// ----------------------------------------------------------------------------
module i2cm_engine #(
  parameter int unsigned MAX_BYTES = i2cm_pkg::MaxBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2cm_pkg::i2cm_item_t item_i,
  output i2cm_pkg::i2cm_res_t  res_o
);
  import i2cm_pkg::*;

  localparam int unsigned BW = $clog2(MAX_BYTES + 1);

  i2cm_phase_e   phase_q, phase_d;
  logic [3:0]    bit_idx_q, bit_idx_d;
  logic [7:0]    shift_q, shift_d;
  logic [BW-1:0] left_q, left_d;
  logic          is_read_q, is_read_d;
  logic          ok_q, ok_d;
  logic          sda_q, sda_d;
  logic          scl_q, scl_d;

  logic [31:0]   cnt_w;
  logic [31:0]   cnt_sat;
  logic [3:0]    bit_inc;
  logic [7:0]    rx_shift;

  assign cnt_w    = 32'(item_i.byte_count);
  assign cnt_sat  = (cnt_w > 32'(MAX_BYTES)) ? 32'(MAX_BYTES) : cnt_w;
  assign bit_inc  = bit_idx_q + 4'd1;
  assign rx_shift = {shift_q[6:0], item_i.sda_in};

  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    left_d    = left_q;
    is_read_d = is_read_q;
    ok_d      = ok_q;
    sda_d     = sda_q;
    scl_d     = scl_q;
    res_o     = '0;

    unique case (phase_q)
      PH_ST_LOW: begin
        scl_d     = 1'b0;
        bit_idx_d = '0;
        phase_d   = PH_WB_SET;
      end
      PH_WB_LOAD: begin
        shift_d          = item_i.write_byte;
        res_o.byte_taken = 1'b1;
        left_d           = left_q - BW'(1);
        sda_d            = item_i.write_byte[7];
        phase_d          = PH_WB_RISE;
      end
      PH_WB_SET: begin
        sda_d   = shift_q[7];
        phase_d = PH_WB_RISE;
      end
      PH_WB_RISE: begin
        scl_d   = 1'b1;
        phase_d = PH_WB_FALL;
      end
      PH_WB_FALL: begin
        scl_d     = 1'b0;
        shift_d   = {shift_q[6:0], 1'b0};
        bit_idx_d = bit_inc;
        phase_d   = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_REL : PH_WB_SET;
      end
      PH_ACK_REL: begin
        sda_d   = 1'b1;
        scl_d   = 1'b1;
        phase_d = PH_ACK_SAMPLE;
      end
      PH_ACK_SAMPLE: begin
        scl_d = 1'b0;
        priority if (item_i.sda_in) begin
          ok_d    = 1'b0;
          phase_d = PH_STOP_LOW;
        end else if (left_q == '0) begin
          ok_d    = 1'b1;
          phase_d = PH_STOP_LOW;
        end else begin
          bit_idx_d = '0;
          if (is_read_q) begin
            left_d  = left_q - BW'(1);
            shift_d = '0;
            phase_d = PH_RB_RISE;
          end else begin
            phase_d = PH_WB_LOAD;
          end
        end
      end
      PH_RB_RISE: begin
        scl_d   = 1'b1;
        phase_d = PH_RB_SAMPLE;
      end
      PH_RB_SAMPLE: begin
        if (item_i.scl_in) begin
          shift_d   = rx_shift;
          scl_d     = 1'b0;
          bit_idx_d = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            res_o.read_valid = 1'b1;
            res_o.read_byte  = rx_shift;
            phase_d          = PH_RB_ACK;
          end else begin
            phase_d = PH_RB_RISE;
          end
        end
      end
      PH_RB_ACK: begin
        sda_d   = (left_q == '0);
        phase_d = PH_RB_ACK_RISE;
      end
      PH_RB_ACK_RISE: begin
        scl_d   = 1'b1;
        phase_d = PH_RB_ACK_FALL;
      end
      PH_RB_ACK_FALL: begin
        scl_d = 1'b0;
        sda_d = 1'b1;
        if (left_q == '0) begin
          ok_d    = 1'b1;
          phase_d = PH_STOP_LOW;
        end else begin
          bit_idx_d = '0;
          left_d    = left_q - BW'(1);
          shift_d   = '0;
          phase_d   = PH_RB_RISE;
        end
      end
      PH_STOP_LOW: begin
        sda_d   = 1'b0;
        phase_d = PH_STOP_RISE;
      end
      PH_STOP_RISE: begin
        scl_d   = 1'b1;
        phase_d = PH_STOP_END;
      end
      PH_STOP_END: begin
        sda_d          = 1'b1;
        res_o.done_res = 1'b1;
        res_o.success  = ok_q;
        phase_d        = PH_IDLE;
      end
      PH_IDLE: begin
        sda_d = 1'b1;
        scl_d = 1'b1;
        if (item_i.kind == KIND_WRITE || item_i.kind == KIND_READ) begin
          is_read_d = (item_i.kind == KIND_READ);
          shift_d   = {item_i.target_addr, item_i.kind == KIND_READ};
          left_d    = cnt_sat[BW-1:0];
          bit_idx_d = '0;
          ok_d      = 1'b0;
          sda_d     = 1'b0;  // start: SDA falls with SCL high
          phase_d   = PH_ST_LOW;
        end
      end
    endcase

    res_o.sda_out  = sda_d;
    res_o.scl_out  = scl_d;
    res_o.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_idx_q <= '0;
      shift_q   <= '0;
      left_q    <= '0;
      is_read_q <= 1'b0;
      ok_q      <= 1'b0;
      sda_q     <= 1'b1;
      scl_q     <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      left_q    <= left_d;
      is_read_q <= is_read_d;
      ok_q      <= ok_d;
      sda_q     <= sda_d;
      scl_q     <= scl_d;
    end
  end

  a_bit_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= BITS_PER_BYTE)
    else $error("bit index past one byte");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (sda_q && scl_q))
    else $error("lines not released while idle");

  a_stop_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_STOP_END) |=> (phase_q == PH_IDLE))
    else $error("stop did not return to idle");

  a_stretch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_RB_SAMPLE && !item_i.scl_in)
      |=> ($stable(shift_q) && phase_q == PH_RB_SAMPLE))
    else $error("read bit advanced while SCL stretched");

endmodule

@@ rtl/i2cm_out_stage.sv @@
// ----------------------------------------------------------------------------
// i2cm_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module i2cm_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  i2cm_pkg::i2cm_res_t res_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cm_pkg::i2cm_res_t res_o
);
  import i2cm_pkg::*;

  logic      valid_q;
  i2cm_res_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/i2c_master_byte_transfer_top.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_transfer_top
// I2C master, byte transfers, one open-drain pin step per bus tick item.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------
//   in      | in_valid_i/in_ready_o | kind, target_addr, byte_count,
//           |                       | write_byte, sda_in, scl_in
//   out     | out_valid_o/out_ready_i| sda_out, scl_out, byte_taken,
//           |                       | read_valid, read_byte, busy_res,
//           |                       | done_res, success
//
// One item per cycle sustained while the output is not stalled; an accepted
// item goes through the input register, then the phase sequencer into the
// result register.
// Reset clears the sequencer to idle with both lines released.
// A stalled output holds the result; one further item waits in the input
// register, after which in_ready_o drops.
// ----------------------------------------------------------------------------
module i2c_master_byte_transfer_top #(
  parameter int unsigned MAX_BYTES = i2cm_pkg::MaxBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [6:0] target_addr_i,
  input  logic [8:0] byte_count_i,
  input  logic [7:0] write_byte_i,
  input  logic       sda_in_i,
  input  logic       scl_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       sda_out_o,
  output logic       scl_out_o,
  output logic       byte_taken_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       success_o
);
  import i2cm_pkg::*;

  i2cm_item_t item_in, item_s1;
  i2cm_res_t  res_eng, res_out;
  logic       s1_valid;
  logic       out_space;
  logic       step;

  assign item_in = '{kind:        kind_i,
                     target_addr: target_addr_i,
                     byte_count:  byte_count_i,
                     write_byte:  write_byte_i,
                     sda_in:      sda_in_i,
                     scl_in:      scl_in_i};

  assign step = s1_valid && out_space;

  i2cm_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (step),
    .valid_o    (s1_valid),
    .item_o     (item_s1)
  );

  i2cm_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_s1),
    .res_o  (res_eng)
  );

  i2cm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_eng),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign sda_out_o    = res_out.sda_out;
  assign scl_out_o    = res_out.scl_out;
  assign byte_taken_o = res_out.byte_taken;
  assign read_valid_o = res_out.read_valid;
  assign read_byte_o  = res_out.read_byte;
  assign busy_res_o   = res_out.busy_res;
  assign done_res_o   = res_out.done_res;
  assign success_o    = res_out.success;

endmodule

@@ test/tb_i2c_master_byte_transfer_top.sv @@
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_transfer_top
// Self-checking bench for the byte-transfer I2C master. Bus ticks are offered
// on the input channel. Each one is run through a phase predictor, and every
// result is compared field by field with the oldest predicted result. The
// target side is emulated from the predicted phase: ACK or NACK when an ACK
// is sampled, and SCL stretching on read bits. The run has a short directed
// part and then random transfers under three patterns of back-pressure.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_transfer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  class i2cm_result_checker;
    i2cm_phase_e phase;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [8:0]  left;
    logic        rd;
    logic        ok;
    logic        sda_q;
    logic        scl_q;
    i2cm_res_t   expected_res[$];
    int unsigned errors;

    function new();
      phase   = PH_IDLE;
      bit_idx = '0;
      shreg   = '0;
      left    = '0;
      rd      = 1'b0;
      ok      = 1'b0;
      sda_q   = 1'b1;
      scl_q   = 1'b1;
      errors  = 0;
    endfunction

    function void start_byte();
      bit_idx = '0;
      if (rd) begin
        left  = left - 9'd1;
        shreg = '0;
        phase = PH_RB_RISE;
      end else begin
        phase = PH_WB_LOAD;
      end
    endfunction

    function i2cm_res_t advance_bus(i2cm_item_t it);
      i2cm_res_t r;
      r = '0;
      case (phase)
        PH_ST_LOW: begin
          scl_q   = 1'b0;
          bit_idx = '0;
          phase   = PH_WB_SET;
        end
        PH_WB_LOAD: begin
          shreg        = it.write_byte;
          r.byte_taken = 1'b1;
          left         = left - 9'd1;
          sda_q        = shreg[7];
          phase        = PH_WB_RISE;
        end
        PH_WB_SET: begin
          sda_q = shreg[7];
          phase = PH_WB_RISE;
        end
        PH_WB_RISE: begin
          scl_q = 1'b1;
          phase = PH_WB_FALL;
        end
        PH_WB_FALL: begin
          scl_q   = 1'b0;
          shreg   = {shreg[6:0], 1'b0};
          bit_idx = bit_idx + 4'd1;
          phase   = (bit_idx >= BITS_PER_BYTE) ? PH_ACK_REL : PH_WB_SET;
        end
        PH_ACK_REL: begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          phase = PH_ACK_SAMPLE;
        end
        PH_ACK_SAMPLE: begin
          scl_q = 1'b0;
          if (it.sda_in) begin
            ok    = 1'b0;
            phase = PH_STOP_LOW;
          end else if (left == '0) begin
            ok    = 1'b1;
            phase = PH_STOP_LOW;
          end else begin
            start_byte();
          end
        end
        PH_RB_RISE: begin
          scl_q = 1'b1;
          phase = PH_RB_SAMPLE;
        end
        PH_RB_SAMPLE: begin
          if (it.scl_in) begin
            shreg   = {shreg[6:0], it.sda_in};
            scl_q   = 1'b0;
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= BITS_PER_BYTE) begin
              r.read_valid = 1'b1;
              r.read_byte  = shreg;
              phase        = PH_RB_ACK;
            end else begin
              phase = PH_RB_RISE;
            end
          end
        end
        PH_RB_ACK: begin
          sda_q = (left > '0) ? 1'b0 : 1'b1;
          phase = PH_RB_ACK_RISE;
        end
        PH_RB_ACK_RISE: begin
          scl_q = 1'b1;
          phase = PH_RB_ACK_FALL;
        end
        PH_RB_ACK_FALL: begin
          scl_q = 1'b0;
          sda_q = 1'b1;
          if (left == '0) begin
            ok    = 1'b1;
            phase = PH_STOP_LOW;
          end else begin
            start_byte();
          end
        end
        PH_STOP_LOW: begin
          sda_q = 1'b0;
          phase = PH_STOP_RISE;
        end
        PH_STOP_RISE: begin
          scl_q = 1'b1;
          phase = PH_STOP_END;
        end
        PH_STOP_END: begin
          sda_q     = 1'b1;
          r.done_res = 1'b1;
          r.success  = ok;
          phase      = PH_IDLE;
        end
        default: begin
          phase = PH_IDLE;
          sda_q = 1'b1;
          scl_q = 1'b1;
          if (it.kind == KIND_WRITE || it.kind == KIND_READ) begin
            rd      = (it.kind == KIND_READ);
            shreg   = {it.target_addr, rd};
            left    = (it.byte_count > MaxBytesDef) ? 9'(MaxBytesDef) : it.byte_count;
            bit_idx = '0;
            ok      = 1'b0;
            sda_q   = 1'b0;
            phase   = PH_ST_LOW;
          end
        end
      endcase
      r.sda_out  = sda_q;
      r.scl_out  = scl_q;
      r.busy_res = (phase != PH_IDLE);
      return r;
    endfunction

    function void note_tick(i2cm_item_t it);
      expected_res.push_back(advance_bus(it));
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(i2cm_res_t got);
      i2cm_res_t want;
      if (expected_res.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      want = expected_res.pop_front();
      cmp_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      cmp_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
      cmp_field("byte_taken", 8'(want.byte_taken), 8'(got.byte_taken));
      cmp_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      cmp_field("read_byte", want.read_byte, got.read_byte);
      cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
      cmp_field("success", 8'(want.success), 8'(got.success));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] kind_i;
  logic [6:0] target_addr_i;
  logic [8:0] byte_count_i;
  logic [7:0] write_byte_i;
  logic       sda_in_i;
  logic       scl_in_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       sda_out_o;
  logic       scl_out_o;
  logic       byte_taken_o;
  logic       read_valid_o;
  logic [7:0] read_byte_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic       success_o;

  i2c_master_byte_transfer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .target_addr_i(target_addr_i),
    .byte_count_i (byte_count_i),
    .write_byte_i (write_byte_i),
    .sda_in_i     (sda_in_i),
    .scl_in_i     (scl_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sda_out_o    (sda_out_o),
    .scl_out_o    (scl_out_o),
    .byte_taken_o (byte_taken_o),
    .read_valid_o (read_valid_o),
    .read_byte_o  (read_byte_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .success_o    (success_o)
  );

  i2cm_result_checker sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned nack_pct     = 8;
  int unsigned stretch_pct  = 30;
  int unsigned busy_cmd_pct = 5;
  int unsigned n_items      = 0;
  int unsigned n_results    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // bus tick with target behaviour taken from the predicted phase
  function automatic i2cm_item_t bus_tick();
    i2cm_item_t it;
    it.kind        = ($urandom_range(99) < busy_cmd_pct) ? 2'($urandom_range(3)) : KIND_TICK;
    it.target_addr = 7'($urandom());
    it.byte_count  = 9'($urandom());
    it.write_byte  = 8'($urandom());
    it.sda_in      = 1'($urandom());
    it.scl_in      = 1'($urandom());
    if (sb.phase == PH_ACK_SAMPLE) it.sda_in = ($urandom_range(99) < nack_pct);
    if (sb.phase == PH_RB_SAMPLE) it.scl_in = ($urandom_range(99) >= stretch_pct);
    return it;
  endfunction

  task automatic send_item(i2cm_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= it.kind;
    target_addr_i <= it.target_addr;
    byte_count_i  <= it.byte_count;
    write_byte_i  <= it.write_byte;
    sda_in_i      <= it.sda_in;
    scl_in_i      <= it.scl_in;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(it);
    n_items++;
  endtask

  // nack_at: index of the ACK to refuse, -1 for none, below -1 for random
  task automatic run_txn(logic [1:0] kind, logic [6:0] addr, logic [8:0] count, int nack_at);
    i2cm_item_t it;
    int         acks;
    acks           = 0;
    it             = bus_tick();
    it.kind        = kind;
    it.target_addr = addr;
    it.byte_count  = count;
    send_item(it);
    while (sb.phase != PH_IDLE) begin
      it = bus_tick();
      if (nack_at >= -1 && sb.phase == PH_ACK_SAMPLE) begin
        it.sda_in = (acks == nack_at);
        acks++;
      end
      send_item(it);
    end
  endtask

  function automatic logic [8:0] rand_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 9'($urandom_range(3));
    if (r < 96) return 9'($urandom_range(16, 4));
    return 9'($urandom_range(511, 250));
  endfunction

  task automatic run_random(int unsigned quota);
    i2cm_item_t  it;
    int unsigned start;
    logic [1:0]  txn_kind;
    logic [8:0]  txn_count;
    int          txn_nack;
    start = n_items;
    while (n_items - start < quota) begin
      if ($urandom_range(9) == 0) begin
        it      = bus_tick();
        it.kind = $urandom_range(1) ? KIND_UNUSED : KIND_TICK;
        send_item(it);
      end else begin
        txn_kind  = $urandom_range(1) ? KIND_READ : KIND_WRITE;
        txn_count = rand_count();
        txn_nack  = -2;
        // long transfers are cut short by an early NACK
        if (txn_count > 9'd16) begin
          txn_nack = (txn_kind == KIND_READ) ? 0 : int'($urandom_range(3));
        end
        run_txn(txn_kind, 7'($urandom()), txn_count, txn_nack);
      end
    end
  endtask

  task automatic run_directed();
    i2cm_item_t it;
    run_txn(KIND_WRITE, 7'h00, 9'd0, -1);
    run_txn(KIND_READ, 7'h7F, 9'd0, 0);
    run_txn(KIND_WRITE, 7'h2A, 9'd2, -1);
    run_txn(KIND_WRITE, 7'h55, 9'd3, 2);
    run_txn(KIND_WRITE, 7'h01, 9'd1, 1);
    stretch_pct = 60;
    run_txn(KIND_READ, 7'h01, 9'd3, -1);
    stretch_pct = 30;
    run_txn(KIND_READ, 7'h6B, 9'd1, -1);
    it      = bus_tick();
    it.kind = KIND_UNUSED;
    send_item(it);
    busy_cmd_pct = 50;
    run_txn(KIND_READ, 7'h7F, 9'd2, -1);
    run_txn(KIND_WRITE, 7'h40, 9'd2, -1);
    busy_cmd_pct = 5;
    run_txn(KIND_READ, 7'h00, 9'd511, 0);
    run_txn(KIND_WRITE, 7'h12, 9'd300, 3);
  endtask

  // receiver: random back-pressure plus an occasional long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned next_hold;
    i2cm_res_t   got;
    hold_left   = 0;
    next_hold   = 300;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{sda_out_o, scl_out_o, byte_taken_o, read_valid_o, read_byte_o,
                busy_res_o, done_res_o, success_o};
        sb.check_result(got);
        n_results++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (n_results >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + 3000;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int unsigned stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall = 0;
      else stall++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_TICK;
    target_addr_i <= '0;
    byte_count_i  <= '0;
    write_byte_i  <= '0;
    sda_in_i      <= 1'b1;
    scl_in_i      <= 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 14;
    rx_idle_pct = 77;
    run_directed();
    run_random(140);
    tx_idle_pct = 77;
    rx_idle_pct = 14;
    run_random(140);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(140);
    in_valid_i <= 1'b0;

    while (sb.expected_res.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.expected_res.size() > 0) begin
      $error("%0d results never arrived", sb.expected_res.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
